// ===== sv/fmbq_pkg.sv =====
// shared types and constants for the front/middle/back queue
package fmbq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int OCC_W = 5;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT  = 3'd0,
    FUNC_PUSH_MIDDLE = 3'd1,
    FUNC_PUSH_BACK   = 3'd2,
    FUNC_POP_FRONT   = 3'd3,
    FUNC_POP_MIDDLE  = 3'd4,
    FUNC_POP_BACK    = 3'd5
  } fmbq_func_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic                     was_empty;
    logic                     was_full;
    logic [OCC_W-1:0]         occupancy;
  } fmbq_res_t;

endpackage

// ===== sv/fmbq_if.sv =====
// valid/ready channel interfaces for operation and result words
interface fmbq_in_if
  import fmbq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink (input valid, input func, input push_value, output ready);
endinterface

interface fmbq_out_if
  import fmbq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pop_value;
  logic                     was_empty;
  logic                     was_full;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output pop_value, output was_empty, output was_full,
                  output occupancy, input ready);
  modport sink (input valid, input pop_value, input was_empty, input was_full,
                input occupancy, output ready);
endinterface

// ===== sv/fmbq_store.sv =====
// queue storage: slot shift network, count and per-operation result
module fmbq_store
  import fmbq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     op_en,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [DATA_W-1:0] push_value,
  output fmbq_res_t                res
);

  logic signed [DATA_W-1:0] slots_r [DEPTH];
  logic signed [DATA_W-1:0] slots_nxt [DEPTH];
  logic signed [DATA_W-1:0] up_val [DEPTH];
  logic signed [DATA_W-1:0] down_val [DEPTH];
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [CNT_W-1:0]         ins_pos;
  logic [CNT_W-1:0]         del_pos;
  logic                     is_push;
  logic                     is_pop;
  logic                     full;
  logic                     empty;
  logic                     do_push;
  logic                     do_pop;

  // neighbor values for shifting toward the back (push) or front (pop)
  for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
    if (g == 0) begin : g_first
      assign up_val[g] = push_value;
    end else begin : g_rest
      assign up_val[g] = slots_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign down_val[g] = slots_r[g];
    end else begin : g_mid
      assign down_val[g] = slots_r[g+1];
    end
  end

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    ins_pos = '0;
    del_pos = '0;
    unique case (func)
      FUNC_PUSH_FRONT: begin
        is_push = 1'b1;
      end
      FUNC_PUSH_MIDDLE: begin
        is_push = 1'b1;
        ins_pos = cnt_r >> 1;
      end
      FUNC_PUSH_BACK: begin
        is_push = 1'b1;
        ins_pos = cnt_r;
      end
      FUNC_POP_FRONT: begin
        is_pop = 1'b1;
      end
      FUNC_POP_MIDDLE: begin
        is_pop  = 1'b1;
        del_pos = (cnt_r - CNT_W'(1)) >> 1;
      end
      FUNC_POP_BACK: begin
        is_pop  = 1'b1;
        del_pos = cnt_r - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = op_en && is_push && !full;
  assign do_pop  = op_en && is_pop && !empty;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slots_nxt[i] = slots_r[i];
      if (do_push) begin
        if (CNT_W'(i) == ins_pos) begin
          slots_nxt[i] = push_value;
        end else if (CNT_W'(i) > ins_pos) begin
          slots_nxt[i] = up_val[i];
        end
      end else if (do_pop) begin
        if (CNT_W'(i) >= del_pos) begin
          slots_nxt[i] = down_val[i];
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    res.pop_value = '0;
    if (is_pop) begin
      res.pop_value = empty ? EMPTY_VALUE : slots_r[del_pos[IDX_W-1:0]];
    end
    res.was_empty = is_pop && empty;
    res.was_full  = is_push && full;
    res.occupancy = OCC_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("push did not add one entry");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("pop did not remove one entry");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    op_en |-> !(res.was_empty && res.was_full))
    else $error("empty and full flags together");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !op_en |=> $stable(cnt_r))
    else $error("count moved without an operation");

endmodule

// ===== sv/front_middle_back_queue_top.sv =====
// front/middle/back queue top level: input register, queue store, result register
//
// An ordered queue of up to 16 signed 32-bit entries with push and pop at the
// front, the middle and the back. Every operation word gives exactly one result
// word, in order. The block sustains one operation per clock cycle: the shift
// network of the slot registers settles each operation in a single pass, so the
// only limit is the downstream ready. The result word of an accepted operation
// word passes through the input register and then the result register before it
// appears on the output. Pops on an empty queue return -1 with was_empty set;
// pushes into a full queue are dropped with was_full set.
module front_middle_back_queue_top
  import fmbq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fmbq_in_if.sink     in_ch,
  fmbq_out_if.source  out_ch
);

  logic                     in_vld_r;
  logic [FUNC_W-1:0]        in_func_r;
  logic signed [DATA_W-1:0] in_val_r;
  logic                     out_vld_r;
  fmbq_res_t                out_res_r;
  fmbq_res_t                res;
  logic                     advance;

  // the held word moves on when the result register is free or being drained
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;

  fmbq_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_en      (advance),
    .func       (in_func_r),
    .push_value (in_val_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_func_r <= in_ch.func;
      in_val_r  <= in_ch.push_value;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.pop_value = out_res_r.pop_value;
  assign out_ch.was_empty = out_res_r.was_empty;
  assign out_ch.was_full  = out_res_r.was_full;
  assign out_ch.occupancy = out_res_r.occupancy;

endmodule

// ===== dv/front_middle_back_queue_top_tb.sv =====
// testbench for the front/middle/back queue: directed table, biased random ops, in-order scoreboard
module front_middle_back_queue_top_tb
  import fmbq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;
  localparam int RANDOM_OPS = 1850;

  localparam fmbq_res_t RES_EMPTY = '{EMPTY_VALUE, 1'b1, 1'b0, 5'd0};
  localparam fmbq_res_t RES_FULL = '{32'sd0, 1'b0, 1'b1, 5'd16};
  localparam fmbq_res_t RES_IDLE_FULL = '{32'sd0, 1'b0, 1'b0, 5'd16};
  localparam fmbq_res_t RES_NONE = '0;

  typedef struct {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    bit                       fixed;
    fmbq_res_t                res;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n;

  fmbq_in_if in_ch ();
  fmbq_out_if out_ch ();

  front_middle_back_queue_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // shadow copy of the queue
  logic signed [DATA_W-1:0] shadow_slots [DEPTH];
  int                       shadow_count;

  fmbq_res_t expected_results [$];
  bit        failed = 1'b0;
  int        burst_left = 0;

  // fixed results only where they are obvious; zero-res rows use the shadow queue
  op_row_t directed_ops [25] = '{
    '{FUNC_POP_FRONT,   32'sd0,           1'b1, RES_EMPTY},
    '{FUNC_POP_MIDDLE,  32'sd0,           1'b1, RES_EMPTY},
    '{FUNC_POP_BACK,    32'sd0,           1'b1, RES_EMPTY},
    '{FUNC_PUSH_BACK,   32'sh7fffffff,    1'b1, '{32'sd0, 1'b0, 1'b0, 5'd1}},
    '{FUNC_PUSH_FRONT,  32'sh80000000,    1'b1, '{32'sd0, 1'b0, 1'b0, 5'd2}},
    '{FUNC_PUSH_MIDDLE, 32'sd0,           1'b1, '{32'sd0, 1'b0, 1'b0, 5'd3}},
    '{FUNC_PUSH_BACK,   -32'sd1,          1'b1, '{32'sd0, 1'b0, 1'b0, 5'd4}},
    '{FUNC_PUSH_FRONT,  32'sd1,           1'b1, '{32'sd0, 1'b0, 1'b0, 5'd5}},
    '{FUNC_PUSH_MIDDLE, 32'sh55555555,    1'b1, '{32'sd0, 1'b0, 1'b0, 5'd6}},
    '{FUNC_PUSH_BACK,   32'shaaaaaaaa,    1'b1, '{32'sd0, 1'b0, 1'b0, 5'd7}},
    '{FUNC_PUSH_FRONT,  32'sd8,           1'b1, '{32'sd0, 1'b0, 1'b0, 5'd8}},
    '{FUNC_PUSH_MIDDLE, 32'sd9,           1'b1, '{32'sd0, 1'b0, 1'b0, 5'd9}},
    '{FUNC_PUSH_BACK,   32'sd10,          1'b1, '{32'sd0, 1'b0, 1'b0, 5'd10}},
    '{FUNC_PUSH_FRONT,  32'sd11,          1'b1, '{32'sd0, 1'b0, 1'b0, 5'd11}},
    '{FUNC_PUSH_MIDDLE, 32'sd12,          1'b1, '{32'sd0, 1'b0, 1'b0, 5'd12}},
    '{FUNC_PUSH_BACK,   32'sd13,          1'b1, '{32'sd0, 1'b0, 1'b0, 5'd13}},
    '{FUNC_PUSH_FRONT,  32'sd14,          1'b1, '{32'sd0, 1'b0, 1'b0, 5'd14}},
    '{FUNC_PUSH_MIDDLE, 32'sd15,          1'b1, '{32'sd0, 1'b0, 1'b0, 5'd15}},
    '{FUNC_PUSH_BACK,   32'sd16,          1'b1, '{32'sd0, 1'b0, 1'b0, 5'd16}},
    '{FUNC_PUSH_FRONT,  32'sd17,          1'b1, RES_FULL},
    '{FUNC_PUSH_MIDDLE, 32'sd18,          1'b1, RES_FULL},
    '{FUNC_PUSH_BACK,   32'sd19,          1'b1, RES_FULL},
    '{FUNC_UNUSED_6,    32'sd20,          1'b1, RES_IDLE_FULL},
    '{FUNC_UNUSED_7,    32'sd21,          1'b1, RES_IDLE_FULL},
    '{FUNC_POP_MIDDLE,  32'sd0,           1'b0, RES_NONE}
  };

  function automatic void shadow_insert(input int pos, input logic signed [DATA_W-1:0] v);
    for (int i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
    shadow_slots[pos] = v;
    shadow_count++;
  endfunction

  function automatic logic signed [DATA_W-1:0] shadow_remove(input int pos);
    logic signed [DATA_W-1:0] v;
    v = shadow_slots[pos];
    for (int i = pos; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i+1];
    shadow_count--;
    return v;
  endfunction

  // applies one op to the shadow queue and returns the word it should produce
  function automatic fmbq_res_t apply_queue_op(input logic [FUNC_W-1:0] f,
                                               input logic signed [DATA_W-1:0] v);
    fmbq_res_t r;
    r = '0;
    case (f)
      FUNC_PUSH_FRONT, FUNC_PUSH_MIDDLE, FUNC_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.was_full = 1'b1;
        end else if (f == FUNC_PUSH_FRONT) begin
          shadow_insert(0, v);
        end else if (f == FUNC_PUSH_MIDDLE) begin
          shadow_insert(shadow_count / 2, v);
        end else begin
          shadow_insert(shadow_count, v);
        end
      end
      FUNC_POP_FRONT, FUNC_POP_MIDDLE, FUNC_POP_BACK: begin
        if (shadow_count == 0) begin
          r.was_empty = 1'b1;
          r.pop_value = EMPTY_VALUE;
        end else if (f == FUNC_POP_FRONT) begin
          r.pop_value = shadow_remove(0);
        end else if (f == FUNC_POP_MIDDLE) begin
          r.pop_value = shadow_remove((shadow_count - 1) / 2);
        end else begin
          r.pop_value = shadow_remove(shadow_count - 1);
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // send one op word in bursts with random gaps, then predict once it is taken
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
                         input bit use_fixed, input fmbq_res_t fixed_res);
    fmbq_res_t predicted;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.push_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_queue_op(f, v);
    expected_results.push_back(use_fixed ? fixed_res : predicted);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver stall pattern: always ready, coin flip, periodic, or mostly stalled
  int ready_mode = 0;
  int ready_mode_left = 0;
  int unsigned ready_tick = 0;

  always @(posedge clk) begin
    ready_tick++;
    if (ready_mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_mode_left = $urandom_range(50, 300);
    end else begin
      ready_mode_left--;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= (ready_tick % 5) != 4;
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin : check_results
    fmbq_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result word with nothing expected, actual pop_value %0d",
                 $time, out_ch.pop_value);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        report_field("pop_value", want.pop_value, $signed(out_ch.pop_value));
        report_field("was_empty", want.was_empty, out_ch.was_empty);
        report_field("was_full", want.was_full, out_ch.was_full);
        report_field("occupancy", want.occupancy, out_ch.occupancy);
      end
    end
  end

  initial begin : stimulus
    int push_pct;
    int r;
    logic [FUNC_W-1:0] f;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= '0;
    in_ch.push_value <= '0;
    shadow_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_ops[k])
      send_op(directed_ops[k].func, directed_ops[k].value, directed_ops[k].fixed,
              directed_ops[k].res);
    wait_for_results();

    push_pct = 50;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      // swing between filling and draining so both full and empty come up often
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      if (i == RANDOM_OPS / 2) wait_for_results();
      r = $urandom_range(0, 99);
      if (r < 3) f = $urandom_range(0, 1) ? FUNC_UNUSED_6 : FUNC_UNUSED_7;
      else if (r < 3 + push_pct) f = FUNC_W'($urandom_range(FUNC_PUSH_FRONT, FUNC_PUSH_BACK));
      else f = FUNC_W'($urandom_range(FUNC_POP_FRONT, FUNC_POP_BACK));
      send_op(f, pick_value(), 1'b0, RES_NONE);
    end

    wait_for_results();
    repeat (6) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fmbq_pkg.sv
sv/fmbq_if.sv
sv/fmbq_store.sv
sv/front_middle_back_queue_top.sv
dv/front_middle_back_queue_top_tb.sv
